[src/assert_macros.svh]
// assertion helpers used by isbn_check_digit_validator
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked at every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// checked at every clock edge, reset included
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[src/isbn_pkg.sv]
// ----------------------------------------------------------------------------
// isbn_pkg
// Shared types, constants and modular helpers of the isbn check digit block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package isbn_pkg;

  // capacity per isbn; the first CAPACITY - 1 characters are examined
  localparam int CAPACITY = 20;
  localparam logic [4:0] POS_LIMIT = 5'(CAPACITY - 1);

  // queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  // ascii codes and special values
  localparam logic [7:0] ASCII_ZERO = 8'h30;
  localparam logic [7:0] ASCII_NINE = 8'h39;
  localparam logic [7:0] ASCII_X    = 8'h58;
  localparam logic [7:0] ASCII_NUL  = 8'h00;
  localparam logic [3:0] X_VALUE    = 4'd10;
  localparam logic [3:0] TEN_POS    = 4'd9;   // kept count before the tenth value
  localparam logic [3:0] THIRTEEN_POS = 4'd12;
  localparam logic [3:0] COUNT_MAX  = 4'd14;

  // result kinds
  localparam logic [1:0] KIND_BAD      = 2'd0;
  localparam logic [1:0] KIND_TEN      = 2'd1;
  localparam logic [1:0] KIND_THIRTEEN = 2'd2;

  // character class decided by the front
  typedef enum logic [1:0] {
    CK_DIGIT,
    CK_X,
    CK_NUL,
    CK_OTHER
  } char_kind_t;

  // one classified beat
  typedef struct packed {
    char_kind_t  ck;
    logic [3:0]  value;
    logic        final_char;
  } isbn_beat_t;

  // x mod 11 by binary-weighted compare and subtract
  function automatic logic [3:0] mod11(input logic [7:0] x);
    logic [7:0] r;
    r = x;
    if (r >= 8'd176) r = r - 8'd176;
    if (r >= 8'd88)  r = r - 8'd88;
    if (r >= 8'd44)  r = r - 8'd44;
    if (r >= 8'd22)  r = r - 8'd22;
    if (r >= 8'd11)  r = r - 8'd11;
    return r[3:0];
  endfunction

  // x mod 10 for six-bit values
  function automatic logic [3:0] mod10(input logic [5:0] x);
    logic [5:0] r;
    r = x;
    if (r >= 6'd40) r = r - 6'd40;
    if (r >= 6'd20) r = r - 6'd20;
    if (r >= 6'd10) r = r - 6'd10;
    return r[3:0];
  endfunction

endpackage

`default_nettype wire

[src/isbn_check_digit_validator.sv]
// ----------------------------------------------------------------------------
// isbn_check_digit_validator
// Validates isbn-10 and isbn-13 check digits over a stream of ascii beats.
//
//   channel | signals                         | direction
//   in      | in_valid in_stall character     | beat of one character, final_char
//           | final_char                      | marks the last one
//   out     | out_valid out_stall kind        | one result per final beat
//           | check_ok                        |
//
// one character beat per cycle when nothing stalls; a result passes the front
// register, the queue and the result register after its final beat.
// the back updates its running sums as it takes each beat, which sets the rate.
// reset is synchronous and clears all control state; no clearing pass.
// out_stall holds back only final beats; other beats keep flowing into the
// sums and the queue absorbs short stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module isbn_check_digit_validator (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  character,
  input  wire logic        final_char,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       kind,
  output logic             check_ok
);

  isbn_pkg::isbn_beat_t front_beat;
  isbn_pkg::isbn_beat_t queue_beat;
  logic                 front_valid;
  logic                 front_stall;
  logic                 queue_valid;
  logic                 queue_stall;

  // classify characters
  isbn_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .character  (character),
    .final_char (final_char),
    .beat_valid (front_valid),
    .beat_stall (front_stall),
    .beat       (front_beat)
  );

  // decouple front from back
  isbn_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (front_valid),
    .wr_stall (front_stall),
    .wr_beat  (front_beat),
    .rd_valid (queue_valid),
    .rd_stall (queue_stall),
    .rd_beat  (queue_beat)
  );

  // sums, length and verdict
  isbn_back u_back (
    .clk        (clk),
    .rst        (rst),
    .beat_valid (queue_valid),
    .beat_stall (queue_stall),
    .beat       (queue_beat),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .kind       (kind),
    .check_ok   (check_ok)
  );

  // checks
  `ASSERT_CLK(a_ok_needs_length, out_valid && check_ok |-> kind != isbn_pkg::KIND_BAD, "check_ok set with bad length")
  `ASSERT_CLK(a_queue_stall_nonempty, queue_stall |-> queue_valid, "back stalls on an empty queue")
  `ASSERT_CLK_ALWAYS(a_reset_clears_out, rst |=> !out_valid, "result valid right after reset")

endmodule

`default_nettype wire

[src/isbn_front.sv]
// ----------------------------------------------------------------------------
// isbn_front
// Takes input characters and classifies them into digit, X, NUL or other.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module isbn_front (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [7:0]          character,
  input  wire logic                final_char,
  output logic                     beat_valid,
  input  wire logic                beat_stall,
  output isbn_pkg::isbn_beat_t     beat
);

  isbn_pkg::isbn_beat_t beat_next;

  // hold input while the staged beat cannot move on
  assign in_stall = beat_valid & beat_stall;

  // classify the incoming character
  always_comb begin
    beat_next.final_char = final_char;
    beat_next.value      = 4'(character - isbn_pkg::ASCII_ZERO);
    if (character >= isbn_pkg::ASCII_ZERO && character <= isbn_pkg::ASCII_NINE) begin
      beat_next.ck = isbn_pkg::CK_DIGIT;
    end else if (character == isbn_pkg::ASCII_X) begin
      beat_next.ck = isbn_pkg::CK_X;
    end else if (character == isbn_pkg::ASCII_NUL) begin
      beat_next.ck = isbn_pkg::CK_NUL;
    end else begin
      beat_next.ck = isbn_pkg::CK_OTHER;
    end
  end

  // staging register
  always_ff @(posedge clk) begin
    if (rst) begin
      beat_valid <= 1'b0;
    end else if (!in_stall) begin
      beat_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      beat <= beat_next;
    end
  end

endmodule

`default_nettype wire

[src/isbn_queue.sv]
// ----------------------------------------------------------------------------
// isbn_queue
// Small fifo of classified beats between the front and the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module isbn_queue (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  wr_valid,
  output logic                       wr_stall,
  input  wire isbn_pkg::isbn_beat_t  wr_beat,
  output logic                       rd_valid,
  input  wire logic                  rd_stall,
  output isbn_pkg::isbn_beat_t       rd_beat
);

  localparam logic [isbn_pkg::QPTR_W:0] FULL_COUNT = (isbn_pkg::QPTR_W + 1)'(isbn_pkg::QDEPTH);

  isbn_pkg::isbn_beat_t             slots [isbn_pkg::QDEPTH];
  logic [isbn_pkg::QPTR_W-1:0]      wr_ptr;
  logic [isbn_pkg::QPTR_W-1:0]      rd_ptr;
  logic [isbn_pkg::QPTR_W:0]        count;
  logic                             push;
  logic                             pop;

  assign wr_stall = (count == FULL_COUNT);
  assign rd_valid = (count != '0);
  assign rd_beat  = slots[rd_ptr];
  assign push     = wr_valid & ~wr_stall;
  assign pop      = rd_valid & ~rd_stall;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // slot storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_beat;
    end
  end

endmodule

`default_nettype wire

[src/isbn_back.sv]
// ----------------------------------------------------------------------------
// isbn_back
// Running isbn-10 and isbn-13 sums, length count and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module isbn_back (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  beat_valid,
  output logic                       beat_stall,
  input  wire isbn_pkg::isbn_beat_t  beat,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [1:0]                 kind,
  output logic                       check_ok
);

  logic [4:0] char_position, char_position_next;
  logic [3:0] digit_count, digit_count_next;
  logic [3:0] sum_ten, sum_ten_next;
  logic [3:0] sum_thirteen, sum_thirteen_next;
  logic [3:0] tenth_value, tenth_value_next;
  logic [3:0] thirteenth_value, thirteenth_value_next;

  logic       take;
  logic       keep;
  logic [3:0] keep_val;
  logic [7:0] prod_ten;
  logic [7:0] acc_ten;
  logic [5:0] weighted13;
  logic [5:0] acc_thirteen;
  logic [3:0] expect13;
  logic [1:0] kind_next;
  logic       check_ok_next;

  // a final beat waits while the previous result is still held
  assign beat_stall = beat_valid & out_valid & out_stall & beat.final_char;
  assign take       = beat_valid & ~beat_stall;

  // weighted terms of the kept value
  assign prod_ten     = {4'd0, digit_count + 4'd1} * {4'd0, keep_val};
  assign acc_ten      = {4'd0, sum_ten} + prod_ten;
  assign weighted13   = digit_count[0] ? ({2'd0, keep_val} + {1'b0, keep_val, 1'b0})
                                       : {2'd0, keep_val};
  assign acc_thirteen = {2'd0, sum_thirteen} + weighted13;

  // decide whether the character is kept and with which value
  always_comb begin
    char_position_next = char_position;
    keep               = 1'b0;
    keep_val           = '0;
    if (take && char_position < isbn_pkg::POS_LIMIT) begin
      if (beat.ck == isbn_pkg::CK_NUL) begin
        char_position_next = isbn_pkg::POS_LIMIT;
      end else begin
        char_position_next = char_position + 5'd1;
        if (beat.ck == isbn_pkg::CK_DIGIT) begin
          keep     = 1'b1;
          keep_val = beat.value;
        end else if (beat.ck == isbn_pkg::CK_X && digit_count == isbn_pkg::TEN_POS) begin
          keep     = 1'b1;
          keep_val = isbn_pkg::X_VALUE;
        end
      end
    end
  end

  // running sums and kept values
  always_comb begin
    digit_count_next      = digit_count;
    sum_ten_next          = sum_ten;
    sum_thirteen_next     = sum_thirteen;
    tenth_value_next      = tenth_value;
    thirteenth_value_next = thirteenth_value;
    if (keep) begin
      if (digit_count < isbn_pkg::TEN_POS) begin
        sum_ten_next = isbn_pkg::mod11(acc_ten);
      end
      if (digit_count == isbn_pkg::TEN_POS) begin
        tenth_value_next = keep_val;
      end
      if (digit_count < isbn_pkg::THIRTEEN_POS) begin
        sum_thirteen_next = isbn_pkg::mod10(acc_thirteen);
      end
      if (digit_count == isbn_pkg::THIRTEEN_POS) begin
        thirteenth_value_next = keep_val;
      end
      if (digit_count < isbn_pkg::COUNT_MAX) begin
        digit_count_next = digit_count + 4'd1;
      end
    end
  end

  // verdict from the updated state
  always_comb begin
    expect13      = (sum_thirteen_next == 4'd0) ? 4'd0 : 4'd10 - sum_thirteen_next;
    kind_next     = isbn_pkg::KIND_BAD;
    check_ok_next = 1'b0;
    if (digit_count_next == 4'd10) begin
      kind_next     = isbn_pkg::KIND_TEN;
      check_ok_next = (sum_ten_next == tenth_value_next);
    end else if (digit_count_next == 4'd13) begin
      kind_next     = isbn_pkg::KIND_THIRTEEN;
      check_ok_next = (tenth_value_next != isbn_pkg::X_VALUE) &&
                      (expect13 == thirteenth_value_next);
    end
  end

  // per-isbn state, cleared after each final beat
  always_ff @(posedge clk) begin
    if (rst || (take && beat.final_char)) begin
      char_position    <= '0;
      digit_count      <= '0;
      sum_ten          <= '0;
      sum_thirteen     <= '0;
      tenth_value      <= '0;
      thirteenth_value <= '0;
    end else begin
      char_position    <= char_position_next;
      digit_count      <= digit_count_next;
      sum_ten          <= sum_ten_next;
      sum_thirteen     <= sum_thirteen_next;
      tenth_value      <= tenth_value_next;
      thirteenth_value <= thirteenth_value_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take && beat.final_char) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && beat.final_char) begin
      kind     <= kind_next;
      check_ok <= check_ok_next;
    end
  end

endmodule

`default_nettype wire

[test/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Streams ISBN text into isbn_check_digit_validator one character per beat.
// A predictor in the bench tracks the kept digits and the weighted sums, and
// every result is checked against the oldest predicted verdict. Directed texts
// come first, then well-formed ISBN-10 and ISBN-13 strings with random digits
// and separators, mixed with broken and noisy texts. The run has three idling
// phases: the receiver idles more, then the sender idles more, then neither.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  localparam int ISBN10_LEN = 10;
  localparam int ISBN13_LEN = 13;
  localparam int END_WAIT = 20;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int REPORT_MAX = 10;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } char_beat_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       check_ok;
  } verdict_t;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] character;
  logic       final_char;
  logic       out_valid;
  logic       out_stall;
  logic [1:0] kind;
  logic       check_ok;

  isbn_check_digit_validator u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .character  (character),
    .final_char (final_char),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .kind       (kind),
    .check_ok   (check_ok)
  );

  // pending character beats and predicted verdicts
  char_beat_t char_beats[$];
  verdict_t   expected_verdicts[$];
  logic [7:0] isbn_text[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int sep_pct = 0;
  int queued_beats = 0;
  int accepted_beats = 0;
  int mismatches = 0;
  int quiet_cycles = 0;
  logic in_taken = 1'b0;

  // predictor state of the current isbn
  logic [4:0] pos_cnt = '0;
  logic [3:0] kept_cnt = '0;
  logic [3:0] wsum10 = '0;
  logic [3:0] asum13 = '0;
  logic [3:0] val10 = '0;
  logic [3:0] val13 = '0;

  // clock and reset
  initial begin
    clk = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    character = '0;
    final_char = 1'b0;
    out_stall = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
  end

  // fold one kept value into the running sums
  task automatic keep_value(input int v);
    int n;
    n = kept_cnt;
    if (n < 9) wsum10 = 4'((wsum10 + (n + 1) * v) % 11);
    if (n == 9) val10 = 4'(v);
    if (n < 12) asum13 = 4'((asum13 + ((n % 2) ? 3 : 1) * v) % 10);
    if (n == 12) val13 = 4'(v);
    kept_cnt = (n < isbn_pkg::COUNT_MAX) ? 4'(n + 1) : isbn_pkg::COUNT_MAX;
  endtask

  // predict the verdict, if any, caused by one accepted character beat
  task automatic predict_beat(input logic [7:0] ch, input logic last);
    verdict_t v;
    int chk13;
    if (pos_cnt < isbn_pkg::POS_LIMIT) begin
      if (ch == isbn_pkg::ASCII_NUL) begin
        pos_cnt = isbn_pkg::POS_LIMIT;
      end else begin
        pos_cnt = pos_cnt + 5'd1;
        if (ch >= isbn_pkg::ASCII_ZERO && ch <= isbn_pkg::ASCII_NINE)
          keep_value(ch - isbn_pkg::ASCII_ZERO);
        else if (ch == isbn_pkg::ASCII_X && kept_cnt == isbn_pkg::TEN_POS)
          keep_value(isbn_pkg::X_VALUE);
      end
    end
    if (last) begin
      v.kind = isbn_pkg::KIND_BAD;
      v.check_ok = 1'b0;
      if (kept_cnt == ISBN10_LEN) begin
        v.kind = isbn_pkg::KIND_TEN;
        v.check_ok = (wsum10 == val10);
      end else if (kept_cnt == ISBN13_LEN) begin
        chk13 = (10 - asum13) % 10;
        v.kind = isbn_pkg::KIND_THIRTEEN;
        v.check_ok = (val10 != isbn_pkg::X_VALUE) && (chk13 == val13);
      end
      expected_verdicts.push_back(v);
      pos_cnt = '0;
      kept_cnt = '0;
      wsum10 = '0;
      asum13 = '0;
      val10 = '0;
      val13 = '0;
    end
  endtask

  // append a character, sometimes after a separator
  task automatic add_char(input logic [7:0] ch);
    if (isbn_text.size() != 0 && $urandom_range(99) < sep_pct)
      isbn_text.push_back($urandom_range(1) ? 8'h2d : 8'h20);
    isbn_text.push_back(ch);
  endtask

  // move the text into the beat queue, last mark on its final character
  task automatic emit_isbn();
    char_beat_t b;
    for (int i = 0; i < isbn_text.size(); i++) begin
      b.ch = isbn_text[i];
      b.last = (i == isbn_text.size() - 1);
      char_beats.push_back(b);
    end
    queued_beats += isbn_text.size();
    isbn_text.delete();
  endtask

  task automatic queue_text(input string s);
    for (int i = 0; i < s.len(); i++) isbn_text.push_back(s[i]);
    emit_isbn();
  endtask

  // ten-digit isbn, check digit right or wrong
  task automatic build_isbn10(input bit good);
    int d;
    int wsum;
    int chk;
    wsum = 0;
    for (int k = 1; k <= 9; k++) begin
      d = $urandom_range(9);
      wsum += k * d;
      add_char(8'(isbn_pkg::ASCII_ZERO + d));
    end
    chk = wsum % 11;
    if (!good) chk = (chk + 1 + $urandom_range(9)) % 11;
    add_char(chk == isbn_pkg::X_VALUE ? isbn_pkg::ASCII_X : 8'(isbn_pkg::ASCII_ZERO + chk));
  endtask

  // thirteen-digit isbn, optionally with an X in the tenth place
  task automatic build_isbn13(input bit good, input bit with_x);
    int d;
    int asum;
    int chk;
    asum = 0;
    for (int k = 0; k < 12; k++) begin
      d = $urandom_range(9);
      if (with_x && k == 9) begin
        add_char(isbn_pkg::ASCII_X);
      end else begin
        asum += ((k % 2) ? 3 : 1) * d;
        add_char(8'(isbn_pkg::ASCII_ZERO + d));
      end
    end
    chk = (10 - asum % 10) % 10;
    if (!good) chk = (chk + 1 + $urandom_range(8)) % 10;
    add_char(8'(isbn_pkg::ASCII_ZERO + chk));
  endtask

  // digit run of arbitrary length with stray X and NUL
  task automatic build_digit_run();
    int n;
    int r;
    n = $urandom_range(16);
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      if (r < 10) add_char(isbn_pkg::ASCII_X);
      else if (r < 14) add_char(isbn_pkg::ASCII_NUL);
      else add_char(8'(isbn_pkg::ASCII_ZERO + $urandom_range(9)));
    end
    if (isbn_text.size() == 0) isbn_text.push_back(8'h2d);
  endtask

  // arbitrary bytes
  task automatic build_noise();
    int n;
    int r;
    n = $urandom_range(1, 26);
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      if (r < 10) isbn_text.push_back(isbn_pkg::ASCII_NUL);
      else if (r < 20) isbn_text.push_back(isbn_pkg::ASCII_X);
      else if (r < 50) isbn_text.push_back(8'(isbn_pkg::ASCII_ZERO + $urandom_range(9)));
      else isbn_text.push_back(8'($urandom_range(255)));
    end
  endtask

  // queue random texts until about the given number of beats
  task automatic fill_random(input int target);
    int start;
    int r;
    start = queued_beats;
    while (queued_beats - start < target) begin
      sep_pct = $urandom_range(1) ? 0 : 15;
      r = $urandom_range(99);
      if (r < 35) build_isbn10($urandom_range(9) < 7);
      else if (r < 70) build_isbn13($urandom_range(9) < 7, $urandom_range(9) == 0);
      else if (r < 85) build_digit_run();
      else build_noise();
      emit_isbn();
    end
    sep_pct = 0;
  endtask

  task automatic drain_beats();
    while (accepted_beats != queued_beats) @(posedge clk);
  endtask

  // stimulus phases and end of run
  initial begin
    @(posedge clk);
    while (rst) @(posedge clk);
    send_idle_pct = 38;
    recv_idle_pct = 77;
    queue_text("080442957X");
    queue_text("9780306406157");
    // nul ends the text, the byte after it is ignored
    isbn_text.push_back(isbn_pkg::ASCII_NUL);
    isbn_text.push_back(8'hff);
    emit_isbn();
    fill_random(330);
    drain_beats();
    send_idle_pct = 77;
    recv_idle_pct = 38;
    fill_random(330);
    drain_beats();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    fill_random(340);
    drain_beats();
    while (expected_verdicts.size() != 0) @(posedge clk);
    repeat (END_WAIT) @(posedge clk);
    if (mismatches == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  // driver: new beat at the falling edge once the previous one is taken
  always @(negedge clk) begin : drive_beats
    char_beat_t nxt;
    if (!rst) begin
      if (!in_valid || in_taken) begin
        if (char_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = char_beats.pop_front();
          in_valid <= 1'b1;
          character <= nxt.ch;
          final_char <= nxt.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic flag_mismatch(input string field, input int want, input int got);
    mismatches++;
    if (mismatches <= REPORT_MAX)
      $display("mismatch on %s: expected %0d, got %0d", field, want, got);
  endtask

  // monitor: predict on accepted beats, check accepted results
  always @(posedge clk) begin : check_results
    verdict_t want;
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        predict_beat(character, final_char);
        accepted_beats <= accepted_beats + 1;
      end
      if (out_valid && !out_stall) begin
        if (expected_verdicts.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("unexpected result: kind %0d check_ok %0d", kind, check_ok);
        end else begin
          want = expected_verdicts.pop_front();
          if (kind !== want.kind) flag_mismatch("kind", want.kind, kind);
          if (check_ok !== want.check_ok) flag_mismatch("check_ok", want.check_ok, check_ok);
        end
      end
    end
  end

  // watchdog on cycles without any accepted beat or result
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

endmodule

[sim.f]
+incdir+src
src/isbn_pkg.sv
src/isbn_front.sv
src/isbn_queue.sv
src/isbn_back.sv
src/isbn_check_digit_validator.sv
test/testbench.sv
